/* rtl/procedural_sky_pixel_shader_defines.svh */
// ----------------------------------------------------------------------------
// Sky shader assertion macros
// Concurrent check macros for the sky shader; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PROCEDURAL_SKY_PIXEL_SHADER_DEFINES_SVH
`define PROCEDURAL_SKY_PIXEL_SHADER_DEFINES_SVH
`ifndef SYNTHESIS
`define PSPS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sky shader check failed");
`define PSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sky shader implication failed");
`else
`define PSPS_ASSERT(lbl, clk, rstn, prop)
`define PSPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/psps_pkg.sv */
// ----------------------------------------------------------------------------
// Sky shader package
// Widths, fixed point constants, register codes and the rounding multiply.
// ----------------------------------------------------------------------------
package psps_pkg;

    localparam int MAX_FACE_SIZE = 2048;
    localparam int FS_W          = 12;
    localparam int PIX_W         = 11;
    localparam int CH_W          = 10;
    localparam int CFG_W         = 48;

    // normalizer
    localparam int VEC_W   = 17;   // signed input component
    localparam int DIR_W   = 16;   // signed Q1.14 output component
    localparam int MAG_W   = 16;
    localparam int SS_W    = 32;
    localparam int RAD_SH  = 20;
    localparam int RAD_W   = SS_W + RAD_SH;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DIV_SH  = 25;
    localparam int DIV_W   = MAG_W + DIV_SH + 1;
    localparam int Q_W     = 15;
    localparam int NORM_STAGES = 2 + (ROOT_W + 1) + (Q_W + 1) + 1;

    localparam int POST_STAGES = 16;

    localparam int ONE_Q14  = 16384;
    localparam int K_GROUND = 6554;
    localparam int K_DARK   = 4915;
    localparam int K_DISC   = 22938;
    localparam int K_HALO   = 1966;
    localparam int CH_ONE   = 1 << 22;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;

    typedef enum logic [2:0] {
        CFG_FACE_SIZE,
        CFG_HORIZON,
        CFG_ZENITH,
        CFG_SUN_COLOR,
        CFG_SUN_DIR
    } cfg_idx_t;

    // payload of the power chain stages
    typedef struct packed {
        logic [Q_W-1:0]          w;
        logic [Q_W-1:0]          s4;
        logic [Q_W-1:0]          s8;
        logic [Q_W-1:0]          s16;
        logic [Q_W-1:0]          s64;
        logic [Q_W-1:0]          kh;
        logic [Q_W-1:0]          kg;
        logic signed [DIR_W-1:0] dy;
    } stg_t;

    // round(a*b / 2^14)
    function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
        logic [29:0] p;
        p = 30'(a) * 30'(b) + 30'd8192;
        return p[28:14];
    endfunction

endpackage

/* rtl/psps_norm.sv */
// ----------------------------------------------------------------------------
// Vector normalizer
// Pipelined 3-vector normalize: squares, bit-per-stage square root, then a
// bit-per-stage divide per component. Output in signed Q1.14.
// ----------------------------------------------------------------------------
module psps_norm (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  ce,
    input  logic                                  in_vld,
    input  logic signed [psps_pkg::VEC_W-1:0]     in_x,
    input  logic signed [psps_pkg::VEC_W-1:0]     in_y,
    input  logic signed [psps_pkg::VEC_W-1:0]     in_z,
    output logic                                  out_vld,
    output logic signed [psps_pkg::DIR_W-1:0]     out_x,
    output logic signed [psps_pkg::DIR_W-1:0]     out_y,
    output logic signed [psps_pkg::DIR_W-1:0]     out_z
);
    import psps_pkg::*;

    logic signed [VEC_W-1:0] in_vec [0:2];

    logic                vld_reg  [0:NORM_STAGES-1];

    logic                sgn_a_reg [0:2];
    logic [MAG_W-1:0]    mag_a_reg [0:2];
    logic                sgn_b_reg [0:2];
    logic [MAG_W-1:0]    mag_b_reg [0:2];
    logic [SS_W-1:0]     sq_b_reg  [0:2];

    logic [RAD_W:0]      rem_s_reg  [0:ROOT_W];
    logic [RAD_W:0]      res_s_reg  [0:ROOT_W];
    logic [MAG_W-1:0]    mag_s_reg  [0:ROOT_W][0:2];
    logic                sgn_s_reg  [0:ROOT_W][0:2];
    logic                zero_s_reg [0:ROOT_W];
    logic [RAD_W:0]      rem_s_next [0:ROOT_W];
    logic [RAD_W:0]      res_s_next [0:ROOT_W];

    logic [DIV_W-1:0]    rem_d_reg  [0:Q_W][0:2];
    logic [Q_W-1:0]      q_d_reg    [0:Q_W][0:2];
    logic [ROOT_W:0]     den_d_reg  [0:Q_W];
    logic                sgn_d_reg  [0:Q_W][0:2];
    logic                zero_d_reg [0:Q_W];
    logic [DIV_W-1:0]    rem_d_next [0:Q_W][0:2];
    logic [Q_W-1:0]      q_d_next   [0:Q_W][0:2];

    logic signed [DIR_W-1:0] out_reg  [0:2];
    logic signed [DIR_W-1:0] out_next [0:2];

    logic [SS_W-1:0]     ss_sum;

    assign in_vec[0] = in_x;
    assign in_vec[1] = in_y;
    assign in_vec[2] = in_z;

    assign ss_sum = sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];

    // restoring square root, one result bit per stage
    always_comb begin : sq_step
        logic [RAD_W:0] bit_v;
        logic [RAD_W:0] trial;
        rem_s_next[0] = {1'b0, ss_sum, {RAD_SH{1'b0}}};
        res_s_next[0] = '0;
        for (int k = 1; k <= ROOT_W; k++) begin
            bit_v = (RAD_W+1)'(1) << (2 * (ROOT_W - k));
            trial = res_s_reg[k-1] + bit_v;
            if (rem_s_reg[k-1] >= trial) begin
                rem_s_next[k] = rem_s_reg[k-1] - trial;
                res_s_next[k] = (res_s_reg[k-1] >> 1) + bit_v;
            end else begin
                rem_s_next[k] = rem_s_reg[k-1];
                res_s_next[k] = res_s_reg[k-1] >> 1;
            end
        end
    end

    // quotient = ((m << 25) + r) / (2r), one quotient bit per stage
    always_comb begin : div_step
        logic [DIV_W-1:0] dsh;
        for (int c = 0; c < 3; c++) begin
            rem_d_next[0][c] = (DIV_W'(mag_s_reg[ROOT_W][c]) << DIV_SH)
                             + DIV_W'(res_s_reg[ROOT_W][ROOT_W-1:0]);
            q_d_next[0][c]   = '0;
        end
        for (int i = 1; i <= Q_W; i++) begin
            dsh = DIV_W'(den_d_reg[i-1]) << (Q_W - i);
            for (int c = 0; c < 3; c++) begin
                if (rem_d_reg[i-1][c] >= dsh) begin
                    rem_d_next[i][c] = rem_d_reg[i-1][c] - dsh;
                    q_d_next[i][c]   = q_d_reg[i-1][c] | (Q_W'(1) << (Q_W - i));
                end else begin
                    rem_d_next[i][c] = rem_d_reg[i-1][c];
                    q_d_next[i][c]   = q_d_reg[i-1][c];
                end
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (zero_d_reg[Q_W]) begin
                out_next[c] = '0;
            end else if (sgn_d_reg[Q_W][c]) begin
                out_next[c] = -$signed({1'b0, q_d_reg[Q_W][c]});
            end else begin
                out_next[c] = $signed({1'b0, q_d_reg[Q_W][c]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NORM_STAGES; k++) vld_reg[k] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < NORM_STAGES; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int c = 0; c < 3; c++) begin
                sgn_a_reg[c] <= in_vec[c][VEC_W-1];
                mag_a_reg[c] <= in_vec[c][VEC_W-1] ? MAG_W'(-in_vec[c])
                                                   : in_vec[c][MAG_W-1:0];
                sgn_b_reg[c] <= sgn_a_reg[c];
                mag_b_reg[c] <= mag_a_reg[c];
                sq_b_reg[c]  <= SS_W'(mag_a_reg[c]) * SS_W'(mag_a_reg[c]);
                mag_s_reg[0][c] <= mag_b_reg[c];
                sgn_s_reg[0][c] <= sgn_b_reg[c];
            end
            zero_s_reg[0] <= (ss_sum == '0);
            for (int k = 0; k <= ROOT_W; k++) begin
                rem_s_reg[k] <= rem_s_next[k];
                res_s_reg[k] <= res_s_next[k];
            end
            for (int k = 1; k <= ROOT_W; k++) begin
                zero_s_reg[k] <= zero_s_reg[k-1];
                for (int c = 0; c < 3; c++) begin
                    mag_s_reg[k][c] <= mag_s_reg[k-1][c];
                    sgn_s_reg[k][c] <= sgn_s_reg[k-1][c];
                end
            end
            den_d_reg[0]  <= {res_s_reg[ROOT_W][ROOT_W-1:0], 1'b0};
            zero_d_reg[0] <= zero_s_reg[ROOT_W];
            for (int c = 0; c < 3; c++) sgn_d_reg[0][c] <= sgn_s_reg[ROOT_W][c];
            for (int i = 1; i <= Q_W; i++) begin
                den_d_reg[i]  <= den_d_reg[i-1];
                zero_d_reg[i] <= zero_d_reg[i-1];
                for (int c = 0; c < 3; c++) sgn_d_reg[i][c] <= sgn_d_reg[i-1][c];
            end
            for (int i = 0; i <= Q_W; i++) begin
                for (int c = 0; c < 3; c++) begin
                    rem_d_reg[i][c] <= rem_d_next[i][c];
                    q_d_reg[i][c]   <= q_d_next[i][c];
                end
            end
            for (int c = 0; c < 3; c++) out_reg[c] <= out_next[c];
        end
    end

    assign out_vld = vld_reg[NORM_STAGES-1];
    assign out_x   = out_reg[0];
    assign out_y   = out_reg[1];
    assign out_z   = out_reg[2];

endmodule

/* rtl/procedural_sky_pixel_shader.sv */
// An input transfer passes the input register, a normalizer and the post stages to reach m_valid.
// Throughput: one pixel per cycle; every stage advances together, and the
// whole pipeline holds while a finished pixel waits on m_ready.
// Depth is set by the square root (one root bit per stage) and the divider
// (one quotient bit per stage) in each normalizer.
// Reset: synchronous, active low; clears valid bits and loads config registers with defaults.
// ----------------------------------------------------------------------------
// Procedural sky pixel shader
// Cube face texel to sky RGB: direction normalize, ground/sky blend, sun
// disc and halo, clamp and byte rounding.
// ----------------------------------------------------------------------------
`include "procedural_sky_pixel_shader_defines.svh"

module procedural_sky_pixel_shader (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [2:0]                       cfg_index,
    input  logic [psps_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_face,
    input  logic [psps_pkg::PIX_W-1:0]       s_col,
    input  logic [psps_pkg::PIX_W-1:0]       s_row,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_red,
    output logic [7:0]                       m_green,
    output logic [7:0]                       m_blue
);
    import psps_pkg::*;

    // configuration
    logic [FS_W-1:0]     face_size_reg, face_size_next;
    logic [3*CH_W-1:0]   horizon_reg, horizon_next;
    logic [3*CH_W-1:0]   zenith_reg, zenith_next;
    logic [3*CH_W-1:0]   sun_color_reg, sun_color_next;
    logic [CFG_W-1:0]    sun_dir_reg, sun_dir_next;

    logic                ce;

    logic                t0_vld_reg;
    logic [2:0]          face_reg;
    logic [PIX_W-1:0]    col_reg;
    logic [PIX_W-1:0]    row_reg;

    logic [FS_W-1:0]     fs_eff;
    logic signed [13:0]  u_c, v_c;
    logic signed [VEC_W-1:0] s_v, u_v, v_v;
    logic signed [VEC_W-1:0] dv_x, dv_y, dv_z;

    logic                pix_vld, sun_vld;
    logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
    logic signed [DIR_W-1:0] sun_x, sun_y, sun_z;

    logic                p_vld_reg [1:POST_STAGES];

    logic signed [31:0]  prod_reg [0:2];
    logic signed [DIR_W-1:0] dy1_reg;
    logic [Q_W-1:0]      t1_reg;
    logic [Q_W-1:0]      ay;

    stg_t                st_reg  [2:14];
    stg_t                st_next [2:14];

    logic [24:0]         base_reg [0:2];
    logic [25:0]         sunc_reg [0:2];
    logic [24:0]         base_next [0:2];
    logic [25:0]         sunc_next [0:2];
    logic [7:0]          rgb_reg  [0:2];
    logic [7:0]          rgb_next [0:2];

    assign ce      = !p_vld_reg[POST_STAGES] || m_ready;
    assign s_ready = ce;

    // register writes
    always_comb begin
        face_size_next = face_size_reg;
        horizon_next   = horizon_reg;
        zenith_next    = zenith_reg;
        sun_color_next = sun_color_reg;
        sun_dir_next   = sun_dir_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FACE_SIZE: face_size_next = cfg_data[FS_W-1:0];
                CFG_HORIZON:   horizon_next   = cfg_data[3*CH_W-1:0];
                CFG_ZENITH:    zenith_next    = cfg_data[3*CH_W-1:0];
                CFG_SUN_COLOR: sun_color_next = cfg_data[3*CH_W-1:0];
                CFG_SUN_DIR:   sun_dir_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_size_reg <= FS_W'(256);
            horizon_reg   <= '0;
            zenith_reg    <= '0;
            sun_color_reg <= '0;
            sun_dir_reg   <= CFG_W'(ONE_Q14);
        end else begin
            face_size_reg <= face_size_next;
            horizon_reg   <= horizon_next;
            zenith_reg    <= zenith_next;
            sun_color_reg <= sun_color_next;
            sun_dir_reg   <= sun_dir_next;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_vld_reg <= 1'b0;
        end else if (ce) begin
            t0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce && s_valid) begin
            face_reg <= s_face;
            col_reg  <= s_col;
            row_reg  <= s_row;
        end
    end

    // unnormalized direction through the texel centre
    always_comb begin
        if (face_size_reg == '0) begin
            fs_eff = FS_W'(1);
        end else if (face_size_reg > FS_W'(MAX_FACE_SIZE)) begin
            fs_eff = FS_W'(MAX_FACE_SIZE);
        end else begin
            fs_eff = face_size_reg;
        end
        u_c = $signed({2'b00, col_reg, 1'b1}) - $signed({2'b00, fs_eff});
        v_c = $signed({2'b00, row_reg, 1'b1}) - $signed({2'b00, fs_eff});
        s_v = $signed({{(VEC_W-FS_W){1'b0}}, fs_eff});
        u_v = VEC_W'(u_c);
        v_v = VEC_W'(v_c);
        case (face_reg)
            FACE_PX: begin dv_x = s_v;  dv_y = -v_v; dv_z = -u_v; end
            FACE_NX: begin dv_x = -s_v; dv_y = -v_v; dv_z = u_v;  end
            FACE_PY: begin dv_x = u_v;  dv_y = s_v;  dv_z = v_v;  end
            FACE_NY: begin dv_x = u_v;  dv_y = -s_v; dv_z = -v_v; end
            FACE_PZ: begin dv_x = u_v;  dv_y = -v_v; dv_z = s_v;  end
            default: begin dv_x = -u_v; dv_y = -v_v; dv_z = -s_v; end
        endcase
    end

    psps_norm u_pix_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (t0_vld_reg),
        .in_x    (dv_x),
        .in_y    (dv_y),
        .in_z    (dv_z),
        .out_vld (pix_vld),
        .out_x   (dir_x),
        .out_y   (dir_y),
        .out_z   (dir_z)
    );

    // sun runs alongside each pixel so a fresh write is seen by the next item
    psps_norm u_sun_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (t0_vld_reg),
        .in_x    (VEC_W'($signed(sun_dir_reg[15:0]))),
        .in_y    (VEC_W'($signed(sun_dir_reg[31:16]))),
        .in_z    (VEC_W'($signed(sun_dir_reg[47:32]))),
        .out_vld (sun_vld),
        .out_x   (sun_x),
        .out_y   (sun_y),
        .out_z   (sun_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= POST_STAGES; k++) p_vld_reg[k] <= 1'b0;
        end else if (ce) begin
            p_vld_reg[1] <= pix_vld;
            for (int k = 2; k <= POST_STAGES; k++) p_vld_reg[k] <= p_vld_reg[k-1];
        end
    end

    assign ay = dir_y[DIR_W-1] ? Q_W'(-dir_y) : '0;

    // dot product, ground factor and power chain
    always_comb begin : pow_chain
        logic signed [33:0] dot;
        logic [33:0]        rnd;
        dot = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]);
        rnd = 34'(dot) + 34'd8192;
        st_next[2]    = '0;
        st_next[2].dy = dy1_reg;
        st_next[2].kg = qmul(Q_W'(K_GROUND), Q_W'(ONE_Q14) - t1_reg);
        if (dot <= 0) begin
            st_next[2].w = '0;
        end else if (rnd[33:14] > 20'(ONE_Q14)) begin
            st_next[2].w = Q_W'(ONE_Q14);
        end else begin
            st_next[2].w = rnd[28:14];
        end
        for (int k = 3; k <= 14; k++) begin
            st_next[k] = st_reg[k-1];
            case (k)
                3, 5, 7, 9: st_next[k].w = qmul(st_reg[k-1].w, st_reg[k-1].w);
                4: begin
                    st_next[k].w  = qmul(st_reg[k-1].w, st_reg[k-1].w);
                    st_next[k].s4 = st_next[k].w;
                end
                6: begin
                    st_next[k].w   = qmul(st_reg[k-1].w, st_reg[k-1].w);
                    st_next[k].s16 = st_next[k].w;
                    st_next[k].kh  = qmul(st_reg[k-1].s8, Q_W'(K_HALO));
                end
                8: begin
                    st_next[k].w   = qmul(st_reg[k-1].w, st_reg[k-1].w);
                    st_next[k].s64 = st_next[k].w;
                end
                10: st_next[k].w = qmul(st_reg[k-1].w, st_reg[k-1].s64);
                11: st_next[k].w = qmul(st_reg[k-1].w, st_reg[k-1].s16);
                12: st_next[k].w = qmul(st_reg[k-1].w, st_reg[k-1].s8);
                13: st_next[k].w = qmul(st_reg[k-1].w, st_reg[k-1].s4);
                // s220 -> disc weight
                14: st_next[k].w = qmul(st_reg[k-1].w, Q_W'(K_DISC));
                default: ;
            endcase
        end
        // s8 is captured after the squaring at stage 5
        st_next[5].s8 = st_next[5].w;
    end

    // channel mix; stage 14 carries the disc weight in w
    always_comb begin
        logic [CH_W-1:0] h, z, c;
        logic [Q_W-1:0]  t;
        logic [26:0]     acc;
        logic [30:0]     sc;
        for (int k = 0; k < 3; k++) begin
            h = horizon_reg[CH_W*k +: CH_W];
            z = zenith_reg[CH_W*k +: CH_W];
            c = sun_color_reg[CH_W*k +: CH_W];
            t = st_reg[14].dy[Q_W-1:0];
            if (st_reg[14].dy[DIR_W-1]) begin
                base_next[k] = 25'(h) * 25'(st_reg[14].kg);
            end else begin
                base_next[k] = 25'(h) * 25'(Q_W'(ONE_Q14) - t) + 25'(z) * 25'(t);
            end
            sunc_next[k] = 26'(c) * 26'(st_reg[14].w) + 26'(c) * 26'(st_reg[14].kh);
            acc = 27'(base_reg[k]) + 27'(sunc_reg[k]);
            if (acc > 27'(CH_ONE)) acc = 27'(CH_ONE);
            sc = 31'(acc) * 31'd255 + 31'(CH_ONE / 2);
            rgb_next[k] = sc[29:22];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg[0] <= 32'(dir_x) * 32'(sun_x);
            prod_reg[1] <= 32'(dir_y) * 32'(sun_y);
            prod_reg[2] <= 32'(dir_z) * 32'(sun_z);
            dy1_reg     <= dir_y;
            t1_reg      <= qmul(Q_W'(K_DARK), ay);
            for (int k = 2; k <= 14; k++) st_reg[k] <= st_next[k];
            for (int k = 0; k < 3; k++) begin
                base_reg[k] <= base_next[k];
                sunc_reg[k] <= sunc_next[k];
                rgb_reg[k]  <= rgb_next[k];
            end
        end
    end

    assign m_valid = p_vld_reg[POST_STAGES];
    assign m_red   = rgb_reg[0];
    assign m_green = rgb_reg[1];
    assign m_blue  = rgb_reg[2];

    `PSPS_ASSERT(a_norm_align, aclk, aresetn, pix_vld == sun_vld)
    `PSPS_ASSERT_IMP(a_sd_bound, aclk, aresetn, p_vld_reg[2], st_reg[2].w <= Q_W'(ONE_Q14))
    `PSPS_ASSERT_IMP(a_kg_bound, aclk, aresetn, p_vld_reg[2], st_reg[2].kg <= Q_W'(K_GROUND))

endmodule
